// ===== rtl/core/lzwdse_pkg.sv =====
// Package for the LZW dictionary string expander.
// Holds operation and status codes, field widths, the sequencer state type
// and parameter defaults. No dependencies.
`default_nettype none

package lzwdse_pkg;

    // Parameter defaults for the top level.
    localparam int CODE_BITS_DEF  = 12;
    localparam int MAX_STRING_DEF = 64;

    // Fixed field widths of the stream payloads.
    localparam int FUNC_W   = 2;
    localparam int CODE_W   = 13;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    // Magnitude bits of a non-negative code (the sign bit sits above them).
    localparam int CODE_MAG_W = CODE_W - 1;

    // Input tdata layout: code, entry_prefix, entry_byte from bit 0 up.
    localparam int IN_DATA_W = ((2 * CODE_W + BYTE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((BYTE_W + 7) / 8) * 8;

    // Operation codes carried in tuser.
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EXPAND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIRST  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEG  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LONG = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WALK,
        S_SRD,
        S_SOUT,
        S_ERR
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/lzw_dictionary_string_expander_top.sv =====
// Top level of the LZW dictionary string expander: dictionary memory,
// reversal stack, chain-walk sequencer and output register.
// Depends on lzwdse_pkg.
//
//  channel  | dir | tdata                                   | tuser       | tlast
//  ---------+-----+-----------------------------------------+-------------+-----------
//  s_axis   | in  | code[12:0] prefix[25:13] byte[33:26]    | func[1:0]   | -
//  m_axis   | out | out_byte[7:0]                           | status[1:0] | last
//
// A negative code or an over-long chain gives one error transaction. An expand
// or first-character query walks the chain link by link through the one
// dictionary memory port (registered read), then reads the bytes back from the
// stack (registered read); a first-character query sends only the first byte.
// Reset clears only the control state; dictionary entries are undefined until
// written and no clearing pass runs. The block takes no input while busy, and a
// stalled output holds its transaction in the output register.
`default_nettype none

module lzw_dictionary_string_expander_top #(
    parameter int CODE_BITS  = lzwdse_pkg::CODE_BITS_DEF,
    parameter int MAX_STRING = lzwdse_pkg::MAX_STRING_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // code[12:0], entry_prefix[25:13], entry_byte[33:26], zero fill above
    input  wire logic [lzwdse_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  wire logic [lzwdse_pkg::FUNC_W-1:0]       s_axis_tuser,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // out_byte[7:0]
    output logic [lzwdse_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // status[1:0]
    output logic [lzwdse_pkg::STATUS_W-1:0]          m_axis_tuser,
    output logic                                     m_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready
);

    localparam int DEPTH  = 2 ** CODE_BITS;
    localparam int ENT_W  = lzwdse_pkg::CODE_W + lzwdse_pkg::BYTE_W;
    localparam int CNT_W  = $clog2(MAX_STRING + 1);
    localparam int SP_W   = $clog2(MAX_STRING);

    // Input field split.
    logic [lzwdse_pkg::FUNC_W-1:0] in_func;
    logic [lzwdse_pkg::CODE_W-1:0] in_code;
    logic [lzwdse_pkg::CODE_W-1:0] in_prefix;
    logic [lzwdse_pkg::BYTE_W-1:0] in_byte;
    logic                          in_accept;

    assign in_func   = s_axis_tuser;
    assign in_code   = s_axis_tdata[lzwdse_pkg::CODE_W-1:0];
    assign in_prefix = s_axis_tdata[2*lzwdse_pkg::CODE_W-1:lzwdse_pkg::CODE_W];
    assign in_byte   = s_axis_tdata[2*lzwdse_pkg::CODE_W+lzwdse_pkg::BYTE_W-1:
                                    2*lzwdse_pkg::CODE_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Sequencer registers.
    lzwdse_pkg::t_state               r_state, n_state;
    logic [CODE_BITS-1:0]             r_addr, n_addr;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic [SP_W-1:0]                  r_ptr, n_ptr;
    logic                             r_first, n_first;
    logic [lzwdse_pkg::STATUS_W-1:0]  r_err, n_err;

    // Output register.
    logic                             r_out_valid, n_out_valid;
    logic [lzwdse_pkg::BYTE_W-1:0]    r_out_byte, n_out_byte;
    logic                             r_out_last, n_out_last;
    logic [lzwdse_pkg::STATUS_W-1:0]  r_out_status, n_out_status;

    // Memories and their registered read data.
    logic [ENT_W-1:0]                 r_dict_mem [DEPTH];
    logic [lzwdse_pkg::BYTE_W-1:0]    r_stack_mem [MAX_STRING];
    logic [ENT_W-1:0]                 r_dict_rd;
    logic [lzwdse_pkg::BYTE_W-1:0]    r_stack_rd;

    logic                             dict_we;
    logic                             stack_we;
    logic                             out_free;

    logic [lzwdse_pkg::CODE_W-1:0]    rd_prefix;
    logic [lzwdse_pkg::BYTE_W-1:0]    rd_byte;

    assign rd_prefix = r_dict_rd[ENT_W-1:lzwdse_pkg::BYTE_W];
    assign rd_byte   = r_dict_rd[lzwdse_pkg::BYTE_W-1:0];
    assign out_free  = !r_out_valid || m_axis_tready;

    // Dictionary memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (dict_we) begin
            r_dict_mem[CODE_BITS'(in_code[lzwdse_pkg::CODE_MAG_W-1:0])] <=
                {in_prefix, in_byte};
        end
        r_dict_rd <= r_dict_mem[r_addr];
    end

    // Reversal stack: pushed during the walk, read back top down.
    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack_mem[r_cnt[SP_W-1:0]] <= rd_byte;
        end
        r_stack_rd <= r_stack_mem[r_ptr];
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzwdse_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_cnt        <= n_cnt;
        r_ptr        <= n_ptr;
        r_first      <= n_first;
        r_err        <= n_err;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    // Next state and datapath control.
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_ptr        = r_ptr;
        n_first      = r_first;
        n_err        = r_err;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        dict_we      = 1'b0;
        stack_we     = 1'b0;
        s_axis_tready = 1'b0;

        unique case (r_state)
            lzwdse_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_accept && in_func != lzwdse_pkg::FUNC_NONE) begin
                    if (in_code[lzwdse_pkg::CODE_W-1]) begin
                        // Negative code on any operation.
                        n_err   = lzwdse_pkg::ST_NEG;
                        n_state = lzwdse_pkg::S_ERR;
                    end else if (in_func == lzwdse_pkg::FUNC_WRITE) begin
                        dict_we = 1'b1;
                    end else begin
                        n_addr  = CODE_BITS'(in_code[lzwdse_pkg::CODE_MAG_W-1:0]);
                        n_cnt   = '0;
                        n_first = (in_func == lzwdse_pkg::FUNC_FIRST);
                        n_state = lzwdse_pkg::S_RD;
                    end
                end
            end

            lzwdse_pkg::S_RD: begin
                // Dictionary read of r_addr is in flight.
                n_state = lzwdse_pkg::S_WALK;
            end

            lzwdse_pkg::S_WALK: begin
                if (r_cnt == CNT_W'(MAX_STRING)) begin
                    n_err   = lzwdse_pkg::ST_LONG;
                    n_state = lzwdse_pkg::S_ERR;
                end else begin
                    stack_we = 1'b1;
                    n_cnt    = r_cnt + CNT_W'(1);
                    if (rd_prefix[lzwdse_pkg::CODE_W-1]) begin
                        // Root reached: the top of the stack is the first byte.
                        n_ptr   = r_cnt[SP_W-1:0];
                        n_state = lzwdse_pkg::S_SRD;
                    end else begin
                        n_addr  = CODE_BITS'(rd_prefix[lzwdse_pkg::CODE_MAG_W-1:0]);
                        n_state = lzwdse_pkg::S_RD;
                    end
                end
            end

            lzwdse_pkg::S_SRD: begin
                // Stack read of r_ptr is in flight.
                n_state = lzwdse_pkg::S_SOUT;
            end

            lzwdse_pkg::S_SOUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_stack_rd;
                    n_out_status = lzwdse_pkg::ST_OK;
                    n_out_last   = (r_ptr == '0) || r_first;
                    if ((r_ptr == '0) || r_first) begin
                        n_state = lzwdse_pkg::S_IDLE;
                    end else begin
                        n_ptr   = r_ptr - SP_W'(1);
                        n_state = lzwdse_pkg::S_SRD;
                    end
                end
            end

            lzwdse_pkg::S_ERR: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = '0;
                    n_out_last   = 1'b1;
                    n_out_status = r_err;
                    n_state      = lzwdse_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lzwdse_pkg::S_IDLE;
            end
        endcase
    end

    // Output ports.
    assign m_axis_tdata  = lzwdse_pkg::OUT_DATA_W'(r_out_byte);
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tvalid = r_out_valid;

    // The walk never pushes beyond the stack.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_STRING) || r_state == lzwdse_pkg::S_IDLE)
        else $error("chain counter beyond string bound");

    // An accepted, non-negative expand or query starts a dictionary read.
    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !in_code[lzwdse_pkg::CODE_W-1] &&
         (in_func == lzwdse_pkg::FUNC_EXPAND || in_func == lzwdse_pkg::FUNC_FIRST))
        |=> r_state == lzwdse_pkg::S_RD)
        else $error("expand did not start a chain walk");

    // Error transactions end the item and carry a zero byte.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != lzwdse_pkg::ST_OK)
        |-> (m_axis_tlast && r_out_byte == '0))
        else $error("error transaction without last or with data");

    // A stalled output transaction is not replaced by a new one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(r_out_byte)))
        else $error("output transaction overwritten while stalled");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the LZW dictionary string expander.
// Drives dictionary writes, string expansions and first-character queries,
// and checks every output transaction against a local model. Needs lzwdse_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam int CODE_BITS    = lzwdse_pkg::CODE_BITS_DEF;
    localparam int MAX_STRING   = lzwdse_pkg::MAX_STRING_DEF;
    localparam int DICT_DEPTH   = 1 << CODE_BITS;
    localparam int ITEM_TARGET  = 380;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 400;
    localparam int LONG_CHAIN   = 66;

    // Field types of the input and output transactions.
    typedef logic [lzwdse_pkg::FUNC_W-1:0]   t_func;
    typedef logic [lzwdse_pkg::CODE_W-1:0]   t_code;
    typedef logic [lzwdse_pkg::BYTE_W-1:0]   t_byte;
    typedef logic [lzwdse_pkg::STATUS_W-1:0] t_status;

    // Prefix values that mark a root entry.
    localparam t_code ROOT_MARK = '1;
    localparam t_code NEG_MIN   = 13'h1000;

    // One input transaction; code and prefix are two's complement.
    typedef struct packed {
        t_func func;
        t_code code;
        t_code prefix;
        t_byte tail;
    } t_request;

    // One output transaction.
    typedef struct packed {
        t_byte   symbol;
        logic    last;
        t_status status;
    } t_symbol;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic [lzwdse_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    t_func                             s_axis_tuser  = lzwdse_pkg::FUNC_NONE;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [lzwdse_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    t_status                           m_axis_tuser;
    logic                              m_axis_tlast;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;

    lzw_dictionary_string_expander_top #(
        .CODE_BITS (CODE_BITS),
        .MAX_STRING(MAX_STRING)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    // Requests waiting to be driven, and the byte stream predicted for them.
    t_request request_queue[$];
    t_symbol  pending_bytes[$];

    // Local copy of the dictionary, updated as writes are accepted.
    t_code dict_prefix [DICT_DEPTH];
    t_byte dict_char   [DICT_DEPTH];
    t_byte chain_stack [MAX_STRING];

    // Stimulus bookkeeping: which entries may be picked for reads.
    bit gen_listed  [DICT_DEPTH];
    int listed_codes[$];
    int generated_count = 0;
    int counted_items   = 0;

    int accepted_count = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;

    t_request drive_req;
    int gap_left   = 0;
    int burst_left = 4;
    int stall_left = 0;
    int run_left   = 3;

    // Clock.
    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic t_symbol make_symbol(t_byte b, logic l, t_status st);
        t_symbol s;
        s.symbol = b;
        s.last   = l;
        s.status = st;
        return s;
    endfunction

    // Works out the bytes a request produces and updates the dictionary copy.
    task automatic predict_request(input t_request rq);
        logic [CODE_BITS-1:0] idx;
        int unsigned depth;
        bit done;
        bit too_long;
        if (rq.func == lzwdse_pkg::FUNC_NONE) begin
            return;
        end
        if (rq.code[lzwdse_pkg::CODE_W-1]) begin
            pending_bytes.push_back(make_symbol('0, 1'b1, lzwdse_pkg::ST_NEG));
            return;
        end
        idx = rq.code[CODE_BITS-1:0];
        if (rq.func == lzwdse_pkg::FUNC_WRITE) begin
            dict_prefix[idx] = rq.prefix;
            dict_char[idx]   = rq.tail;
            return;
        end
        // Walk the prefix chain, collecting bytes last to first.
        depth    = 0;
        done     = 1'b0;
        too_long = 1'b0;
        while (!done && !too_long) begin
            if (depth >= MAX_STRING) begin
                too_long = 1'b1;
            end else begin
                chain_stack[depth] = dict_char[idx];
                depth++;
                if (dict_prefix[idx][lzwdse_pkg::CODE_W-1]) begin
                    done = 1'b1;
                end else begin
                    idx = dict_prefix[idx][CODE_BITS-1:0];
                end
            end
        end
        if (too_long) begin
            pending_bytes.push_back(make_symbol('0, 1'b1, lzwdse_pkg::ST_LONG));
        end else if (rq.func == lzwdse_pkg::FUNC_FIRST) begin
            pending_bytes.push_back(make_symbol(chain_stack[depth-1], 1'b1,
                                                lzwdse_pkg::ST_OK));
        end else begin
            for (int k = 0; k < depth; k++) begin
                pending_bytes.push_back(make_symbol(chain_stack[depth-1-k],
                                                    k == depth - 1, lzwdse_pkg::ST_OK));
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Queues a request and tracks which dictionary entries become readable.
    function automatic void gen_push(t_func func, t_code code, t_code prefix, t_byte tail,
                                     bit listed);
        t_request rq;
        int idx;
        rq.func   = func;
        rq.code   = code;
        rq.prefix = prefix;
        rq.tail   = tail;
        request_queue.push_back(rq);
        generated_count++;
        if (func != lzwdse_pkg::FUNC_NONE) begin
            counted_items++;
        end
        idx = int'(code[CODE_BITS-1:0]);
        if (func == lzwdse_pkg::FUNC_WRITE && !code[lzwdse_pkg::CODE_W-1]) begin
            if (listed && !gen_listed[idx]) begin
                gen_listed[idx] = 1'b1;
                listed_codes.push_back(idx);
            end
        end
    endfunction

    // Picks a written entry, often one of the most recent, so chains grow.
    function automatic int pick_written();
        int n;
        n = listed_codes.size();
        if (n > 8 && $urandom_range(0, 1) == 1) begin
            return listed_codes[n - 1 - $urandom_range(0, 7)];
        end
        return listed_codes[$urandom_range(0, n - 1)];
    endfunction

    function automatic t_code rand_negative();
        t_code v;
        if ($urandom_range(0, 1) == 1) begin
            return ROOT_MARK;
        end
        v = t_code'($urandom_range(0, DICT_DEPTH - 1));
        v[lzwdse_pkg::CODE_W-1] = 1'b1;
        return v;
    endfunction

    // Reset and stimulus.
    initial begin
        t_code c;
        t_code p;
        t_func f;
        int next_code;
        int base;
        int r;

        // Directed part: field extremes, every operation and the error cases.
        gen_push(lzwdse_pkg::FUNC_WRITE, 13'd0, ROOT_MARK, 8'h00, 1'b1);
        gen_push(lzwdse_pkg::FUNC_WRITE, 13'd4095, NEG_MIN, 8'hFF, 1'b1);
        gen_push(lzwdse_pkg::FUNC_WRITE, 13'd1, 13'd0, 8'hA5, 1'b1);
        gen_push(lzwdse_pkg::FUNC_WRITE, 13'd2, 13'd1, 8'h5A, 1'b1);
        gen_push(lzwdse_pkg::FUNC_WRITE, 13'd4094, 13'd4095, 8'h80, 1'b1);
        gen_push(lzwdse_pkg::FUNC_WRITE, 13'h0AAA, 13'd2, 8'h01, 1'b1);
        gen_push(lzwdse_pkg::FUNC_WRITE, 13'h0555, 13'h0AAA, 8'h7F, 1'b1);
        gen_push(lzwdse_pkg::FUNC_EXPAND, 13'd0, '0, '0, 1'b0);
        gen_push(lzwdse_pkg::FUNC_EXPAND, 13'd4095, '0, '0, 1'b0);
        gen_push(lzwdse_pkg::FUNC_EXPAND, 13'h0555, '0, '0, 1'b0);
        gen_push(lzwdse_pkg::FUNC_FIRST, 13'h0555, '0, '0, 1'b0);
        gen_push(lzwdse_pkg::FUNC_FIRST, 13'd4094, '0, '0, 1'b0);
        // Negative codes: an error on every operation, and a write stores nothing.
        gen_push(lzwdse_pkg::FUNC_WRITE, ROOT_MARK, 13'd0, 8'h33, 1'b0);
        gen_push(lzwdse_pkg::FUNC_EXPAND, ROOT_MARK, '0, '0, 1'b0);
        gen_push(lzwdse_pkg::FUNC_FIRST, NEG_MIN, '0, '0, 1'b0);
        gen_push(lzwdse_pkg::FUNC_EXPAND, 13'd4095, '0, '0, 1'b0);
        // The undefined operation is ignored.
        gen_push(lzwdse_pkg::FUNC_NONE, 13'h1ABC, 13'h0123, 8'hC3, 1'b0);
        // An entry that is its own prefix forms a loop, which ends in a too-long error.
        gen_push(lzwdse_pkg::FUNC_WRITE, 13'd3, 13'd3, 8'h11, 1'b0);
        gen_push(lzwdse_pkg::FUNC_EXPAND, 13'd3, '0, '0, 1'b0);
        gen_push(lzwdse_pkg::FUNC_FIRST, 13'd3, '0, '0, 1'b0);
        // Two entries that point at each other.
        gen_push(lzwdse_pkg::FUNC_WRITE, 13'd4, ROOT_MARK, 8'h22, 1'b0);
        gen_push(lzwdse_pkg::FUNC_WRITE, 13'd5, 13'd4, 8'h44, 1'b0);
        gen_push(lzwdse_pkg::FUNC_WRITE, 13'd4, 13'd5, 8'h22, 1'b0);
        gen_push(lzwdse_pkg::FUNC_EXPAND, 13'd5, '0, '0, 1'b0);

        // A chain running just past the string bound, probed on both sides.
        base = $urandom_range(256, DICT_DEPTH - LONG_CHAIN - 1);
        gen_push(lzwdse_pkg::FUNC_WRITE, t_code'(base), ROOT_MARK,
                 t_byte'($urandom_range(0, 255)), 1'b0);
        for (int k = 1; k < LONG_CHAIN; k++) begin
            gen_push(lzwdse_pkg::FUNC_WRITE, t_code'(base + k), t_code'(base + k - 1),
                     t_byte'($urandom_range(0, 255)), 1'b0);
        end
        gen_push(lzwdse_pkg::FUNC_EXPAND, t_code'(base + MAX_STRING - 1), '0, '0, 1'b0);
        gen_push(lzwdse_pkg::FUNC_EXPAND, t_code'(base + MAX_STRING), '0, '0, 1'b0);
        gen_push(lzwdse_pkg::FUNC_FIRST, t_code'(base + MAX_STRING - 1), '0, '0, 1'b0);
        gen_push(lzwdse_pkg::FUNC_FIRST, t_code'(base + MAX_STRING), '0, '0, 1'b0);
        gen_push(lzwdse_pkg::FUNC_EXPAND, t_code'(base + MAX_STRING - 2), '0, '0, 1'b0);

        // Random part: mostly dictionary growth as a decoder would do it.
        next_code = $urandom_range(256, 1024);
        while (counted_items < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                if ($urandom_range(0, 9) < 7) begin
                    c = t_code'(next_code);
                    next_code = (next_code + 1) % DICT_DEPTH;
                end else begin
                    c = t_code'($urandom_range(0, DICT_DEPTH - 1));
                end
                gen_push(lzwdse_pkg::FUNC_WRITE, c, t_code'(pick_written()),
                         t_byte'($urandom_range(0, 255)), 1'b1);
                if ($urandom_range(0, 9) < 6) begin
                    gen_push(lzwdse_pkg::FUNC_EXPAND, c, t_code'($urandom),
                             t_byte'($urandom), 1'b0);
                end
            end else if (r < 55) begin
                gen_push(lzwdse_pkg::FUNC_EXPAND, t_code'(pick_written()),
                         t_code'($urandom), t_byte'($urandom), 1'b0);
            end else if (r < 65) begin
                gen_push(lzwdse_pkg::FUNC_FIRST, t_code'(pick_written()),
                         t_code'($urandom), t_byte'($urandom), 1'b0);
            end else if (r < 75) begin
                c = t_code'($urandom_range(0, DICT_DEPTH - 1));
                gen_push(lzwdse_pkg::FUNC_WRITE, c, rand_negative(),
                         t_byte'($urandom_range(0, 255)), 1'b1);
            end else if (r < 82) begin
                // Rewriting an entry may close a loop in the chains.
                c = t_code'(pick_written());
                p = t_code'(pick_written());
                gen_push(lzwdse_pkg::FUNC_WRITE, c, p, t_byte'($urandom_range(0, 255)), 1'b1);
            end else if (r < 92) begin
                f = t_func'($urandom_range(0, 2));
                gen_push(f, rand_negative(), t_code'($urandom), t_byte'($urandom), 1'b0);
            end else begin
                gen_push(lzwdse_pkg::FUNC_NONE, t_code'($urandom), t_code'($urandom),
                         t_byte'($urandom), 1'b0);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < generated_count || pending_bytes.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Driver: feeds requests in bursts with random gaps between them.
    always @(posedge i_clk) begin : drive
        logic                             next_valid;
        logic [lzwdse_pkg::IN_DATA_W-1:0] packed_data;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_request(drive_req);
                accepted_count++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_queue.size() > 0) begin
                    drive_req   = request_queue.pop_front();
                    packed_data = '0;
                    packed_data[lzwdse_pkg::CODE_W-1:0] = drive_req.code;
                    packed_data[2*lzwdse_pkg::CODE_W-1:lzwdse_pkg::CODE_W] =
                        drive_req.prefix;
                    packed_data[2*lzwdse_pkg::CODE_W+lzwdse_pkg::BYTE_W-1:
                                2*lzwdse_pkg::CODE_W] = drive_req.tail;
                    s_axis_tdata <= packed_data;
                    s_axis_tuser <= drive_req.func;
                    next_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 4) == 0) begin
                        gap_left   = 0;
                        burst_left = 50;
                    end else begin
                        gap_left   = $urandom_range(1, 8);
                        burst_left = $urandom_range(0, 10);
                    end
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Monitor: checks each output transaction and stalls on its own pattern.
    always @(posedge i_clk) begin : collect
        t_symbol want;
        logic    next_ready;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_bytes.size() == 0) begin
                    report_mismatch("result with none expected", 0,
                                    32'({m_axis_tuser, m_axis_tlast, m_axis_tdata}));
                end else begin
                    want = pending_bytes.pop_front();
                    if (m_axis_tdata !== lzwdse_pkg::OUT_DATA_W'(want.symbol)) begin
                        report_mismatch("out_byte", 32'(want.symbol), 32'(m_axis_tdata));
                    end
                    if (m_axis_tlast !== want.last) begin
                        report_mismatch("last", 32'(want.last), 32'(m_axis_tlast));
                    end
                    if (m_axis_tuser !== want.status) begin
                        report_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left   = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 6);
                    stall_left = $urandom_range(1, 12);
                end
            end
            m_axis_tready <= next_ready;
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
